### design/cncs_pkg.sv
// ----------------------------------------------------------------------------
// cncs_pkg
// Shared types and constants for the checkerboard co-occurrence sum block.
// ----------------------------------------------------------------------------
package cncs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SIZE_W     = 9;
    localparam int WEIGHT_W   = 16;
    localparam int VOXEL_W    = 2 * SAMPLE_W;
    localparam int TOTAL_W    = 63;
    localparam int PROD1_W    = 2 * SAMPLE_W;
    localparam int PROD2_W    = PROD1_W + WEIGHT_W;
    localparam int FRAC_SHIFT = 15;
    localparam int TERM_W     = PROD2_W - FRAC_SHIFT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_X_DEF  = 256;
    localparam int MAX_Y_DEF  = 256;
    localparam int MAX_Z_DEF  = 256;

    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(256);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);
    localparam logic [TOTAL_W-1:0]  SUM_LIMIT    = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Z = 3'd5;

    // Neighbour pair being processed
    typedef enum logic [1:0] {
        PAIR_X = 2'd0,
        PAIR_Y = 2'd1,
        PAIR_Z = 2'd2
    } pair_t;

    typedef struct packed {
        logic  capture;
        logic  mul1;
        logic  mul2;
        logic  acc;
        logic  commit;
        pair_t pair;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

endpackage

### design/cncs_ram.sv
// ----------------------------------------------------------------------------
// cncs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cncs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/cncs_datapath.sv
// ----------------------------------------------------------------------------
// cncs_datapath
// Config registers, position counters, slice stores, shared multiplier path,
// saturating accumulator and output register.
// ----------------------------------------------------------------------------
module cncs_datapath #(
    parameter int MAX_X = cncs_pkg::MAX_X_DEF,
    parameter int MAX_Y = cncs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = cncs_pkg::MAX_Z_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cncs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cncs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [cncs_pkg::VOXEL_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,
    input  cncs_pkg::cmd_t                     cmd,
    output cncs_pkg::status_t                  status
);

    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);
    localparam int ZW    = $clog2(MAX_Z + 1);
    localparam int DEPTH = MAX_X * MAX_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = cncs_pkg::SAMPLE_W;

    logic [cncs_pkg::SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [cncs_pkg::WEIGHT_W-1:0] weight_x_reg, weight_y_reg, weight_z_reg;
    logic [cncs_pkg::VOXEL_W-1:0]  cur_reg, prev_reg, prev_next;
    logic [XW-1:0]                 pos_x_reg, pos_x_next;
    logic [YW-1:0]                 pos_y_reg, pos_y_next;
    logic [ZW-1:0]                 pos_z_reg, pos_z_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [cncs_pkg::TOTAL_W-1:0]  sum_reg, sum_next;
    logic [cncs_pkg::PROD1_W-1:0]  prod1_reg, prod1_next;
    logic [cncs_pkg::PROD2_W-1:0]  prod2_reg, prod2_next;
    logic [cncs_pkg::TOTAL_W-1:0]  out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic [ZW-1:0] sz;
    logic [XW-1:0] px_inc;
    logic [YW-1:0] py_inc;
    logic [ZW-1:0] pz_inc;
    logic          x_end, y_end, z_end, last;
    logic          even, pair_ok, restart;

    logic [cncs_pkg::VOXEL_W-1:0]  rd_y, rd_z, other;
    logic [SW-1:0]                 kk, ll;
    logic [cncs_pkg::WEIGHT_W-1:0] weight;
    logic [cncs_pkg::TERM_W-1:0]   term;
    logic [63:0]                   sum_add;

    // Size clamping: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (size_x_reg == '0) begin
            sx = XW'(1);
        end else if (32'(size_x_reg) > MAX_X) begin
            sx = XW'(MAX_X);
        end else begin
            sx = XW'(size_x_reg);
        end
        if (size_y_reg == '0) begin
            sy = YW'(1);
        end else if (32'(size_y_reg) > MAX_Y) begin
            sy = YW'(MAX_Y);
        end else begin
            sy = YW'(size_y_reg);
        end
        if (size_z_reg == '0) begin
            sz = ZW'(1);
        end else if (32'(size_z_reg) > MAX_Z) begin
            sz = ZW'(MAX_Z);
        end else begin
            sz = ZW'(size_z_reg);
        end
    end

    assign px_inc = pos_x_reg + XW'(1);
    assign py_inc = pos_y_reg + YW'(1);
    assign pz_inc = pos_z_reg + ZW'(1);
    assign x_end  = (px_inc >= sx);
    assign y_end  = (py_inc >= sy);
    assign z_end  = (pz_inc >= sz);
    assign last   = x_end && y_end && z_end;
    assign even   = ~(pos_x_reg[0] ^ pos_y_reg[0] ^ pos_z_reg[0]);

    assign restart = cfg_we && ((cfg_index == cncs_pkg::REG_SIZE_X) ||
                                (cfg_index == cncs_pkg::REG_SIZE_Y) ||
                                (cfg_index == cncs_pkg::REG_SIZE_Z));

    // Two copies of the slice so both neighbours are read in the same cycle
    cncs_ram #(.WIDTH(cncs_pkg::VOXEL_W), .DEPTH(DEPTH)) u_ram_y (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (idx_reg),
        .wdata (cur_reg),
        .re    (cmd.capture),
        .raddr (idx_reg - AW'(sx)),
        .rdata (rd_y)
    );

    cncs_ram #(.WIDTH(cncs_pkg::VOXEL_W), .DEPTH(DEPTH)) u_ram_z (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (idx_reg),
        .wdata (cur_reg),
        .re    (cmd.capture),
        .raddr (idx_reg),
        .rdata (rd_z)
    );

    always_comb begin
        case (cmd.pair)
            cncs_pkg::PAIR_X: begin
                other   = prev_reg;
                weight  = weight_x_reg;
                pair_ok = (pos_x_reg != '0);
            end
            cncs_pkg::PAIR_Y: begin
                other   = rd_y;
                weight  = weight_y_reg;
                pair_ok = (pos_y_reg != '0);
            end
            cncs_pkg::PAIR_Z: begin
                other   = rd_z;
                weight  = weight_z_reg;
                pair_ok = (pos_z_reg != '0);
            end
            default: begin
                other   = '0;
                weight  = '0;
                pair_ok = 1'b0;
            end
        endcase
    end

    // The even voxel of the pair gives k, the other gives l
    assign kk = even ? cur_reg[SW-1:0]  : other[SW-1:0];
    assign ll = even ? other[2*SW-1:SW] : cur_reg[2*SW-1:SW];

    assign prod1_next = cncs_pkg::PROD1_W'(kk) * cncs_pkg::PROD1_W'(ll);
    assign prod2_next = cncs_pkg::PROD2_W'(prod1_reg) * cncs_pkg::PROD2_W'(weight);
    assign term       = prod2_reg[cncs_pkg::PROD2_W-1:cncs_pkg::FRAC_SHIFT];
    assign sum_add    = 64'(sum_reg) + 64'(term);

    always_comb begin
        sum_next       = sum_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.acc && pair_ok) begin
            if (sum_add > 64'(cncs_pkg::SUM_LIMIT)) begin
                sum_next = cncs_pkg::SUM_LIMIT;
            end else begin
                sum_next = sum_add[cncs_pkg::TOTAL_W-1:0];
            end
        end
        if (cmd.commit) begin
            prev_next = cur_reg;
            if (x_end) begin
                pos_x_next = '0;
                if (y_end) begin
                    pos_y_next = '0;
                    idx_next   = '0;
                    if (z_end) begin
                        pos_z_next     = '0;
                        sum_next       = '0;
                        out_next       = sum_reg;
                        out_valid_next = 1'b1;
                    end else begin
                        pos_z_next = pz_inc;
                    end
                end else begin
                    pos_y_next = py_inc;
                    idx_next   = idx_reg + AW'(1);
                end
            end else begin
                pos_x_next = px_inc;
                idx_next   = idx_reg + AW'(1);
            end
        end
        if (restart) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
            idx_next   = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg    <= cncs_pkg::SIZE_RESET;
            size_y_reg    <= cncs_pkg::SIZE_RESET;
            size_z_reg    <= cncs_pkg::SIZE_RESET;
            weight_x_reg  <= cncs_pkg::WEIGHT_RESET;
            weight_y_reg  <= cncs_pkg::WEIGHT_RESET;
            weight_z_reg  <= cncs_pkg::WEIGHT_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    cncs_pkg::REG_SIZE_X:   size_x_reg   <= cfg_wdata[cncs_pkg::SIZE_W-1:0];
                    cncs_pkg::REG_SIZE_Y:   size_y_reg   <= cfg_wdata[cncs_pkg::SIZE_W-1:0];
                    cncs_pkg::REG_SIZE_Z:   size_z_reg   <= cfg_wdata[cncs_pkg::SIZE_W-1:0];
                    cncs_pkg::REG_WEIGHT_X: weight_x_reg <= cfg_wdata;
                    cncs_pkg::REG_WEIGHT_Y: weight_y_reg <= cfg_wdata;
                    cncs_pkg::REG_WEIGHT_Z: weight_z_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg <= s_tdata;
        end
        if (cmd.mul1) begin
            prod1_reg <= prod1_next;
        end
        if (cmd.mul2) begin
            prod2_reg <= prod2_next;
        end
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

    assign status.last     = last;
    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {1'b0, out_reg};

endmodule

### design/cncs_ctrl.sv
// ----------------------------------------------------------------------------
// cncs_ctrl
// Sequencer: per voxel, runs three neighbour pairs through the shared
// multiply/accumulate path and then commits the voxel.
// ----------------------------------------------------------------------------
module cncs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cncs_pkg::status_t status,
    output cncs_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL1   = 5'b00010,
        ST_MUL2   = 5'b00100,
        ST_ACC    = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    cncs_pkg::pair_t pair_reg, pair_next;

    always_comb begin
        state_next  = state_reg;
        pair_next   = pair_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.mul1    = 1'b0;
        cmd.mul2    = 1'b0;
        cmd.acc     = 1'b0;
        cmd.commit  = 1'b0;
        cmd.pair    = pair_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    pair_next   = cncs_pkg::PAIR_X;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                case (pair_reg)
                    cncs_pkg::PAIR_X: begin
                        pair_next  = cncs_pkg::PAIR_Y;
                        state_next = ST_MUL1;
                    end
                    cncs_pkg::PAIR_Y: begin
                        pair_next  = cncs_pkg::PAIR_Z;
                        state_next = ST_MUL1;
                    end
                    default: begin
                        state_next = ST_COMMIT;
                    end
                endcase
            end
            ST_COMMIT: begin
                // on a volume's last voxel, hold while the previous total is still unread
                if (!(status.last && status.out_busy)) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pair_reg  <= cncs_pkg::PAIR_X;
        end else begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
        end
    end

endmodule

### design/checkerboard_neighbour_cooccurrence_sum.sv
// ----------------------------------------------------------------------------
// checkerboard_neighbour_cooccurrence_sum
// Weighted checkerboard co-occurrence sum of two class maps over a 3D volume.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one voxel per transaction in raster order (x fastest),
//   k_sample in s_tdata[15:0], l_sample in s_tdata[31:16], both Q1.15.
//   m_ channel: one transaction per volume, carrying the saturated total
//   (Q.23 fixed point) in m_tdata[62:0], after the volume's last voxel.
//   cfg_we/cfg_index/cfg_wdata write sizes and Q8.8 weights while idle;
//   writing a size restarts the volume.
//   Each voxel is accepted, then runs its three neighbour pairs (x, y, z)
//   one after another through one shared multiply path (k*l, times weight,
//   accumulate), then commits; the next voxel is taken only after the commit.
//   The total is registered when the volume's last voxel commits.
//   The total sits in an output register; the block keeps taking voxels
//   while it waits. Only if a further volume finishes before it is taken
//   does the commit of that last voxel wait for m_tready.
//   Reset: sizes 256, weights 1.0, position and sum cleared; the slice
//   stores are not cleared, as only entries of the current volume are read.
// ----------------------------------------------------------------------------
module checkerboard_neighbour_cooccurrence_sum #(
    parameter int MAX_X = cncs_pkg::MAX_X_DEF,
    parameter int MAX_Y = cncs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = cncs_pkg::MAX_Z_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cncs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cncs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // k_sample, l_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata    // total, zero pad
);

    cncs_pkg::cmd_t    cmd;
    cncs_pkg::status_t status;

    cncs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cncs_datapath #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### tb/checkerboard_neighbour_cooccurrence_sum_tb.sv
// ----------------------------------------------------------------------------
// checkerboard_neighbour_cooccurrence_sum_tb
// Streams voxel volumes into the block and checks each volume total against
// a built-in co-occurrence predictor. Sizes and weights are reprogrammed
// between phases; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module checkerboard_neighbour_cooccurrence_sum_tb;

    import cncs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 30;
    localparam bit [63:0]   SUM_CAP     = {1'b0, SUM_LIMIT};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SIZE_X;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // k_sample, l_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;          // total, zero pad

    checkerboard_neighbour_cooccurrence_sum u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Predictor state
    bit [VOXEL_W-1:0]  slice_mem [0:MAX_X_DEF*MAX_Y_DEF-1];
    bit [VOXEL_W-1:0]  last_voxel = '0;
    int unsigned       px = 0, py = 0, pz = 0;
    bit [63:0]         sum_acc = '0;
    bit [SIZE_W-1:0]   size_x_r = SIZE_RESET;
    bit [SIZE_W-1:0]   size_y_r = SIZE_RESET;
    bit [SIZE_W-1:0]   size_z_r = SIZE_RESET;
    bit [WEIGHT_W-1:0] weight_x_r = WEIGHT_RESET;
    bit [WEIGHT_W-1:0] weight_y_r = WEIGHT_RESET;
    bit [WEIGHT_W-1:0] weight_z_r = WEIGHT_RESET;

    logic [VOXEL_W-1:0] voxel_queue [$];
    logic [TOTAL_W-1:0] volume_totals [$];
    logic [TOTAL_W-1:0] want_total;

    bit          idle_en = 1'b1;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned eff_size(bit [SIZE_W-1:0] v, int unsigned cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic void restart_volume();
        px = 0;
        py = 0;
        pz = 0;
        sum_acc = '0;
    endfunction

    // even-sum voxel's k times the other voxel's l, weighted and shifted, saturating accumulate
    function automatic void add_pair(bit even, bit [VOXEL_W-1:0] cur,
                                     bit [VOXEL_W-1:0] other, bit [WEIGHT_W-1:0] w);
        bit [63:0] kk, ll, term;
        kk   = even ? cur[15:0] : other[15:0];
        ll   = even ? other[31:16] : cur[31:16];
        term = (kk * ll * w) >> FRAC_SHIFT;
        if (term > SUM_CAP - sum_acc) sum_acc = SUM_CAP;
        else sum_acc = sum_acc + term;
    endfunction

    function automatic void accumulate_voxel(logic [VOXEL_W-1:0] voxel);
        int unsigned sx, sy, sz, idx;
        bit even;
        bit [VOXEL_W-1:0] cur;
        cur  = voxel;
        sx   = eff_size(size_x_r, MAX_X_DEF);
        sy   = eff_size(size_y_r, MAX_Y_DEF);
        sz   = eff_size(size_z_r, MAX_Z_DEF);
        even = ((px + py + pz) & 1) == 0;
        idx  = px + py * sx;
        if (px > 0) add_pair(even, cur, last_voxel, weight_x_r);
        if (py > 0 && idx >= sx) add_pair(even, cur, slice_mem[idx - sx], weight_y_r);
        if (pz > 0) add_pair(even, cur, slice_mem[idx], weight_z_r);
        slice_mem[idx] = cur;
        last_voxel = cur;
        px++;
        if (px >= sx) begin
            px = 0;
            py++;
            if (py >= sy) begin
                py = 0;
                pz++;
                if (pz >= sz) begin
                    volume_totals.push_back(sum_acc[TOTAL_W-1:0]);
                    restart_volume();
                end
            end
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SIZE_X: begin
                size_x_r = val[SIZE_W-1:0];
                restart_volume();
            end
            REG_SIZE_Y: begin
                size_y_r = val[SIZE_W-1:0];
                restart_volume();
            end
            REG_SIZE_Z: begin
                size_z_r = val[SIZE_W-1:0];
                restart_volume();
            end
            REG_WEIGHT_X: weight_x_r = val;
            REG_WEIGHT_Y: weight_y_r = val;
            REG_WEIGHT_Z: weight_z_r = val;
            default: ;
        endcase
    endfunction

    function automatic bit [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SAMPLE_W'(32768);
            2:       return '1;
            3:       return SAMPLE_W'($urandom_range(0, 65535));
            default: return SAMPLE_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic bit [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WEIGHT_RESET;
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void queue_voxels(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            voxel_queue.push_back({rand_sample(), rand_sample()});
    endfunction

    // wait until the sender is empty and every total has come back
    task automatic drain();
        do @(negedge aclk);
        while (voxel_queue.size() != 0 || s_tvalid || volume_totals.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        apply_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic set_volume(input int unsigned nx, input int unsigned ny,
                              input int unsigned nz, input int unsigned wx,
                              input int unsigned wy, input int unsigned wz);
        drain();
        write_reg(REG_SIZE_X, nx);
        write_reg(REG_SIZE_Y, ny);
        write_reg(REG_SIZE_Z, nz);
        write_reg(REG_WEIGHT_X, wx);
        write_reg(REG_WEIGHT_Y, wy);
        write_reg(REG_WEIGHT_Z, wz);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // voxel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_voxel(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (voxel_queue.size() != 0) begin
                    s_tdata  <= voxel_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // total monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (volume_totals.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected total transaction, expected none, actual %0d",
                             $time, m_tdata[TOTAL_W-1:0]);
                end else begin
                    want_total = volume_totals.pop_front();
                    if (m_tdata[TOTAL_W-1:0] !== want_total) begin
                        err_count++;
                        $display("%0t: total mismatch, expected %0d, actual %0d",
                                 $time, want_total, m_tdata[TOTAL_W-1:0]);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned nx, ny, nz, vol, n_vol, rand_items, vols;
        bit paused_once;
        rand_items  = 0;
        vols        = 0;
        paused_once = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // zero sizes act as one: single voxel volumes
        set_volume(0, 0, 0, 65535, 65535, 65535);
        voxel_queue.push_back({16'hFFFF, 16'hFFFF});
        voxel_queue.push_back(32'h0);

        set_volume(2, 2, 2, 65535, 65535, 65535);
        voxel_queue.push_back({16'd32768, 16'd32768});
        voxel_queue.push_back({16'hFFFF, 16'hFFFF});
        voxel_queue.push_back({16'd0, 16'd32768});
        voxel_queue.push_back({16'd32768, 16'd0});
        voxel_queue.push_back({16'd1, 16'hFFFF});
        voxel_queue.push_back({16'hFFFF, 16'd1});
        voxel_queue.push_back({16'd32768, 16'd32768});
        voxel_queue.push_back({16'hAAAA, 16'h5555});

        set_volume(3, 2, 2, 0, 65535, 1);
        queue_voxels(12);

        // oversized sizes, left unfinished so the next size write restarts
        set_volume(511, 511, 511, rand_weight(), rand_weight(), rand_weight());
        queue_voxels(30);
        rand_items += 30;

        // one full volume at the largest size along one axis
        case ($urandom_range(0, 2))
            0:       set_volume(511, 1, 1, rand_weight(), rand_weight(), rand_weight());
            1:       set_volume(1, 256, 1, rand_weight(), rand_weight(), rand_weight());
            default: set_volume(1, 1, 300, rand_weight(), rand_weight(), rand_weight());
        endcase
        queue_voxels(256);
        rand_items += 256;

        while (rand_items < 420 || vols < 20) begin
            idle_en = ($urandom_range(0, 3) != 0);
            nx = $urandom_range(0, 4);
            ny = $urandom_range(0, 3);
            nz = $urandom_range(0, 3);
            set_volume(nx, ny, nz, rand_weight(), rand_weight(), rand_weight());
            vol = eff_size(SIZE_W'(nx), MAX_X_DEF) * eff_size(SIZE_W'(ny), MAX_Y_DEF)
                * eff_size(SIZE_W'(nz), MAX_Z_DEF);
            n_vol = $urandom_range(1, 4);
            for (int unsigned v = 0; v < n_vol; v++) begin
                queue_voxels(vol);
                rand_items += vol;
                vols++;
                if (!paused_once || $urandom_range(0, 7) == 0) begin
                    drain();
                    paused_once = 1'b1;
                end
            end
            if (vol > 1 && $urandom_range(0, 4) == 0) begin
                n_vol = $urandom_range(1, vol - 1);
                queue_voxels(n_vol);
                rand_items += n_vol;
            end
        end

        // closing stretch at full rate
        idle_en = 1'b0;
        set_volume(3, 3, 2, rand_weight(), rand_weight(), rand_weight());
        queue_voxels(54);

        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
